// ===== rtl/core/slq_pkg.sv =====
package slq_pkg;

  // Operation codes carried on mode_i.
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_POP    = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  // Result status codes driven on status_o.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // How the row of cells moves in the update cycle.
  typedef enum logic [1:0] {
    SHIFT_HOLD = 2'd0,
    SHIFT_INS  = 2'd1,
    SHIFT_DEL  = 2'd2,
    SHIFT_POP  = 2'd3
  } shift_e;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic   update;
    shift_e shift;
  } cell_ctrl_t;

  localparam int unsigned ValueOutBits = 32;
  localparam int unsigned CountOutBits = 5;

endpackage

// ===== rtl/core/sorted_list_queue_core.sv =====
// Channel  | Direction | Handshake               | Payload
// command  | in        | start, busy             | mode_i, item_value_i
// result   | out       | result_valid_o (strobe) | status_o, popped_value_o, entry_count_o
//
// A command is taken at a clock edge where start is high and busy is low.
// Each beat first registers the command; then all cells compare against the
// key in parallel and shift by one place.
// The result beat shows for exactly one cycle after that; the receiver cannot
// stall it, and the next command may be taken in that same cycle.
// Reset is asynchronous and active low; it clears the entry count and the
// handshake flags. Entry contents need no reset since only counted cells
// are ever read.
module sorted_list_queue_core #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           mode_i,
  input  logic signed [31:0]                   item_value_i,
  output logic                                 result_valid_o,
  output logic [1:0]                           status_o,
  output logic signed [slq_pkg::ValueOutBits-1:0] popped_value_o,
  output logic [slq_pkg::CountOutBits-1:0]     entry_count_o
);
  import slq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned ExtW = (CntW > CountOutBits) ? CntW : CountOutBits;

  // Command registers, loaded when a beat is accepted.
  logic                         busy_q;
  mode_e                        mode_q;
  logic signed [VALUE_BITS-1:0] key_q;
  logic signed [63:0]           in_ext;

  // Entry count; a cell is valid when its index is below it.
  logic [CntW-1:0] count_q, count_d;

  // Result registers.
  logic                         res_valid_q;
  status_e                      status_q, status_d;
  logic signed [ValueOutBits-1:0] popped_q, popped_d;

  // Cell row wiring.
  logic signed [VALUE_BITS-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]          cell_lt;
  logic [CAPACITY-1:0]          cell_eq;
  cell_ctrl_t                   ctrl;

  logic               is_full, is_empty, found;
  logic signed [63:0] head_ext;
  logic [ExtW-1:0]    count_ext;

  // The input value is sign-extended to 64 bits and then cut to VALUE_BITS.
  assign in_ext = 64'(item_value_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start && !busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy_q) begin
      mode_q <= mode_e'(mode_i);
      key_q  <= in_ext[VALUE_BITS-1:0];
    end
  end

  assign busy = busy_q;

  assign is_full  = (count_q == CntW'(CAPACITY));
  assign is_empty = (count_q == '0);
  // The first equal entry exists exactly when any valid cell matches.
  assign found    = |cell_eq;

  // Decide the shift and the result while the command is in flight.
  always_comb begin
    ctrl.update = 1'b0;
    ctrl.shift  = SHIFT_HOLD;
    count_d     = count_q;
    status_d    = ST_OK;
    popped_d    = '0;
    head_ext    = 64'(cell_value[0]);
    if (busy_q) begin
      unique case (mode_q)
        MODE_INSERT: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.update = 1'b1;
            ctrl.shift  = SHIFT_INS;
            count_d     = count_q + CntW'(1);
          end
        end
        MODE_DELETE: begin
          if (!found) begin
            status_d = ST_NOT_FOUND;
          end else begin
            ctrl.update = 1'b1;
            ctrl.shift  = SHIFT_DEL;
            count_d     = count_q - CntW'(1);
          end
        end
        MODE_POP: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.update = 1'b1;
            ctrl.shift  = SHIFT_POP;
            count_d     = count_q - CntW'(1);
            popped_d    = head_ext[ValueOutBits-1:0];
          end
        end
        MODE_NOP: status_d = ST_OK;
        default:  status_d = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      status_q <= status_d;
      popped_q <= popped_d;
    end
  end

  // The row of cells. Each cell sees its left neighbor's value and compare
  // flag for insertion and its right neighbor's value for removal.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                         left_lt;
    logic signed [VALUE_BITS-1:0] left_value;
    logic signed [VALUE_BITS-1:0] right_value;
    logic                         valid;

    assign valid = (count_q > CntW'(i));

    if (i == 0) begin : g_first
      // A virtual cell before the head counts as smaller than any key.
      assign left_lt    = 1'b1;
      assign left_value = '0;
    end else begin : g_inner
      assign left_lt    = cell_lt[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_mid
      assign right_value = cell_value[i+1];
    end

    slq_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .key_i        (key_q),
      .valid_i      (valid),
      .left_lt_i    (left_lt),
      .left_value_i (left_value),
      .right_value_i(right_value),
      .value_o      (cell_value[i]),
      .lt_o         (cell_lt[i]),
      .eq_o         (cell_eq[i])
    );
  end

  // The count after the operation is shown modulo 32.
  assign count_ext      = ExtW'(count_q);
  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign entry_count_o  = count_ext[CountOutBits-1:0];

endmodule

// ===== rtl/core/slq_cell.sv =====
module slq_cell #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  slq_pkg::cell_ctrl_t          ctrl_i,
  input  logic signed [VALUE_BITS-1:0] key_i,
  input  logic                         valid_i,
  input  logic                         left_lt_i,
  input  logic signed [VALUE_BITS-1:0] left_value_i,
  input  logic signed [VALUE_BITS-1:0] right_value_i,
  output logic signed [VALUE_BITS-1:0] value_o,
  output logic                         lt_o,
  output logic                         eq_o
);
  import slq_pkg::*;

  logic signed [VALUE_BITS-1:0] value_q, value_d;

  // Because the row is sorted, the cells holding values below the key form
  // a prefix, and the first entry equal to the key sits right after it.
  assign lt_o    = valid_i && (value_q < key_i);
  assign eq_o    = valid_i && (value_q == key_i);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    case (ctrl_i.shift)
      SHIFT_INS: begin
        if (lt_o) begin
          value_d = value_q;
        end else if (left_lt_i) begin
          value_d = key_i;
        end else begin
          value_d = left_value_i;
        end
      end
      SHIFT_DEL: begin
        if (!lt_o) begin
          value_d = right_value_i;
        end
      end
      SHIFT_POP: value_d = right_value_i;
      default:   value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      value_q <= value_d;
    end
  end

endmodule

// ===== rtl/core/slq_checker.sv =====
module slq_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                                     clk_i,
  input logic                                     rst_ni,
  input logic                                     start,
  input logic                                     busy,
  input logic                                     result_valid_o,
  input logic [1:0]                               status_o,
  input logic signed [slq_pkg::ValueOutBits-1:0]  popped_value_o,
  input logic [slq_pkg::CountOutBits-1:0]         entry_count_o
);
  import slq_pkg::*;

  localparam logic [CountOutBits-1:0] FullCount = CountOutBits'(CAPACITY);

  // An accepted beat always occupies the block in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // Every busy cycle ends in exactly one result beat.
  a_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> result_valid_o)
    else $error("busy cycle gave no result beat");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result beat without a command");

  // A failed operation returns no value, and the counts match the fault.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != ST_OK) |-> (popped_value_o == '0))
    else $error("failed operation returned a value");

  a_status_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && ((status_o == ST_FULL && entry_count_o != FullCount) ||
                       (status_o == ST_EMPTY && entry_count_o != '0)) |-> 1'b0)
    else $error("status disagrees with entry count");

endmodule

bind sorted_list_queue_core slq_checker #(
  .CAPACITY(CAPACITY)
) u_slq_checker (.*);

// ===== tb/sorted_list_queue_checker.sv =====
`timescale 1ns / 100ps

module sorted_list_queue_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          mode_i,
  input  logic signed [31:0]  item_value_i,
  input  logic                result_valid_o,
  input  logic [1:0]          status_o,
  input  logic signed [31:0]  popped_value_o,
  input  logic [4:0]          entry_count_o,
  output int                  fail_count,
  output int                  pending,
  output int                  beats_checked,
  output int                  full_hits,
  output int                  empty_hits,
  output int                  miss_hits
);
  import slq_pkg::*;

  localparam int unsigned Depth = 16;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] popped;
    logic [4:0]         count;
  } queue_result_t;

  logic signed [31:0] shadow_list [Depth];
  int unsigned        shadow_count;
  queue_result_t      expected_results [$];

  // Applies one command to the shadow list and returns the result it should give.
  task automatic apply_command(input mode_e op, input logic signed [31:0] value,
                               output queue_result_t res);
    int unsigned pos;
    res.status = ST_OK;
    res.popped = '0;
    case (op)
      MODE_INSERT: begin
        if (shadow_count >= Depth) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_list[pos] < value) pos++;
          for (int unsigned i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = value;
          shadow_count++;
        end
      end
      MODE_DELETE: begin
        pos = 0;
        while (pos < shadow_count && shadow_list[pos] != value) pos++;
        if (pos >= shadow_count) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (int unsigned i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      MODE_POP: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped = shadow_list[0];
          for (int unsigned i = 0; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      default: ;
    endcase
    res.count = shadow_count[4:0];
  endtask

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // All signals are read right after the edge, so they hold their pre-edge values.
  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    queue_result_t got;
    if (!rst_ni) begin
      shadow_count = 0;
      expected_results.delete();
      fail_count    = 0;
      pending       = 0;
      beats_checked = 0;
      full_hits     = 0;
      empty_hits    = 0;
      miss_hits     = 0;
    end else begin
      if (result_valid_o) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, actual status %0d", $time,
                   status_o);
        end else begin
          want = expected_results.pop_front();
          beats_checked++;
          if (status_o !== want.status) report("status", want.status, status_o);
          if (popped_value_o !== want.popped) report("popped_value", want.popped,
                                                     popped_value_o);
          if (entry_count_o !== want.count) report("entry_count", want.count,
                                                   entry_count_o);
        end
      end
      if (start && !busy) begin
        apply_command(mode_e'(mode_i), item_value_i, got);
        case (got.status)
          ST_FULL:      full_hits++;
          ST_EMPTY:     empty_hits++;
          ST_NOT_FOUND: miss_hits++;
          default: ;
        endcase
        expected_results.push_back(got);
      end
      pending = expected_results.size();
    end
  end

endmodule

// ===== tb/sorted_list_queue_core_tb.sv =====
`timescale 1ns / 100ps

module sorted_list_queue_core_tb;
  import slq_pkg::*;

  // Generous bound on the whole run.
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomBeats = 1550;
  localparam int unsigned IdlePercent = 12;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               start        = 1'b0;
  logic [1:0]         mode_i       = MODE_NOP;
  logic signed [31:0] item_value_i = '0;

  logic               busy;
  logic               result_valid_o;
  logic [1:0]         status_o;
  logic signed [31:0] popped_value_o;
  logic [4:0]         entry_count_o;

  int fail_count;
  int pending;
  int beats_checked;
  int full_hits;
  int empty_hits;
  int miss_hits;

  // When low, command beats go out back to back with no idle cycles.
  bit idling_on = 1'b1;
  int unsigned cycle_count = 0;

  sorted_list_queue_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .item_value_i   (item_value_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .entry_count_o  (entry_count_o)
  );

  sorted_list_queue_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .item_value_i   (item_value_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .entry_count_o  (entry_count_o),
    .fail_count     (fail_count),
    .pending        (pending),
    .beats_checked  (beats_checked),
    .full_hits      (full_hits),
    .empty_hits     (empty_hits),
    .miss_hits      (miss_hits)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a missing result beat ends up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending);
      $display("simulation failed");
      $finish;
    end
  end

  // Sends one command beat. The task is always entered right after a rising edge,
  // so the nonblocking assignments below take effect after the block has sampled it.
  // Idle cycles come first, which puts gaps in front of the command beat.
  task automatic issue(input mode_e op, input logic signed [31:0] value);
    while (idling_on && $urandom_range(99) < IdlePercent) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    mode_i       <= op;
    item_value_i <= value;
    // busy is read before the edge updates it, so this sees what the block sampled.
    do @(posedge clk_i); while (busy);
  endtask

  // Small values most often, so that duplicates and delete hits are common, plus the
  // signed extremes and fully random words that toggle every bit.
  function automatic logic signed [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45) return $signed($urandom_range(12)) - 6;
    if (sel < 65) begin
      case ($urandom_range(5))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return 32'sh7FFF_FFFE;
        3:       return 32'sh8000_0001;
        4:       return -1;
        default: return 0;
      endcase
    end
    return $signed($urandom());
  endfunction

  // The mix of operations drifts by phase so the list fills to capacity, drains
  // to empty and spends time in between. Mode three shows up now and then.
  function automatic mode_e pick_mode(input int unsigned phase);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 4) return MODE_NOP;
    case (phase % 4)
      0:       return (sel < 70) ? MODE_INSERT : (sel < 85) ? MODE_DELETE : MODE_POP;
      1:       return (sel < 25) ? MODE_INSERT : (sel < 45) ? MODE_DELETE : MODE_POP;
      2:       return (sel < 50) ? MODE_INSERT : (sel < 75) ? MODE_DELETE : MODE_POP;
      default: return (sel < 45) ? MODE_INSERT : (sel < 85) ? MODE_DELETE : MODE_POP;
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: operations on an empty list, mode three, the signed extremes,
    // a duplicate, a delete hit and a miss, a pop of the minimum, filling to
    // capacity, an insert into a full list, and a delete of the head entry.
    issue(MODE_POP, 0);
    issue(MODE_DELETE, 3);
    issue(MODE_NOP, 32'sh5A5A_A5A5);
    issue(MODE_INSERT, 32'sh7FFF_FFFF);
    issue(MODE_INSERT, 32'sh8000_0000);
    issue(MODE_INSERT, 0);
    issue(MODE_INSERT, -1);
    issue(MODE_INSERT, 5);
    issue(MODE_INSERT, 5);
    issue(MODE_DELETE, 5);
    issue(MODE_DELETE, 7);
    issue(MODE_POP, 0);
    for (int i = 0; i < 12; i++) issue(MODE_INSERT, i * 1000 - 5000);
    issue(MODE_INSERT, 42);
    issue(MODE_DELETE, -5000);

    // Random part, with one long stretch of back-to-back beats in the middle.
    for (int unsigned n = 0; n < RandomBeats; n++) begin
      idling_on = !(n >= 600 && n < 900);
      issue(pick_mode(n / 100), pick_value());
    end
    start <= 1'b0;

    // Drain: wait for every owed result, then a few cycles for anything stray.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    $display("checked %0d result beats over directed and random command traffic",
             beats_checked);
    $display("saw %0d inserts into a full list, %0d pops of an empty list, %0d delete misses",
             full_hits, empty_hits, miss_hits);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/slq_pkg.sv
rtl/core/slq_cell.sv
rtl/core/sorted_list_queue_core.sv
rtl/core/slq_checker.sv
tb/sorted_list_queue_checker.sv
tb/sorted_list_queue_core_tb.sv
